// ===== design/sv32_translating_memory_unit_macros.svh =====
// Assertion macros for the Sv32 translating memory unit.
// Assertions are active unless SYNTH is defined.
`ifndef SV32_TRANSLATING_MEMORY_UNIT_MACROS_SVH
`define SV32_TRANSLATING_MEMORY_UNIT_MACROS_SVH
`ifndef SYNTH
`define SV32_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("sv32 assertion failed");
`define SV32_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("sv32 assertion failed");
`else
`define SV32_ASSERT(lbl, prop)
`define SV32_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== design/sv32tm_pkg.sv =====
// Shared codes and helpers for the Sv32 translating memory unit.
// No dependencies.
package sv32tm_pkg;

  localparam logic [2:0] FUNC_LB    = 3'd0;
  localparam logic [2:0] FUNC_LH    = 3'd1;
  localparam logic [2:0] FUNC_LW    = 3'd2;
  localparam logic [2:0] FUNC_SB    = 3'd3;
  localparam logic [2:0] FUNC_SH    = 3'd4;
  localparam logic [2:0] FUNC_SW    = 3'd5;
  localparam logic [2:0] FUNC_FETCH = 3'd6;
  localparam logic [2:0] FUNC_NOP   = 3'd7;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OOM      = 2'd1;
  localparam logic [1:0] ST_MISALIGN = 2'd2;
  localparam logic [1:0] ST_PAGE     = 2'd3;

  // configuration register indexes
  localparam logic CFG_TRANSLATE = 1'b0;
  localparam logic CFG_ROOT      = 1'b1;

  localparam int PTE_V = 0;
  localparam int PTE_R = 1;
  localparam int PTE_W = 2;
  localparam int PTE_X = 3;
  localparam int PTE_A = 6;
  localparam int PTE_D = 7;

  // log2 of the access size in bytes
  function automatic logic [1:0] size_log2(input logic [2:0] func);
    logic [1:0] r;
    case (func)
      FUNC_LB, FUNC_SB: r = 2'd0;
      FUNC_LH, FUNC_SH: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic is_store(input logic [2:0] func);
    return (func == FUNC_SB) || (func == FUNC_SH) || (func == FUNC_SW);
  endfunction

endpackage

// ===== design/sv32_translating_memory_unit.sv =====
// Top level of the Sv32 translating memory unit: word memory, page table
// walker and access sequencer. Uses sv32tm_pkg and the assertion macro header.
//
// The block holds MEM_PAGES*1024 words of memory in one synchronous RAM and
// serves one access per item: byte/half/word loads and stores and word
// fetches. With translate_enable set and the item not marked physical, the
// address goes through a two-level Sv32 walk starting at root_page; each PTE
// read is one RAM access. An item passes through accept, then one issue state
// and one check state per RAM read, then result handoff; faults end early.
// Stores are read-modify-write on the single RAM port. The RAM is not cleared
// at reset: load it with physical stores before reading. The result sits in
// an output register, so a new item is taken while a result waits.
`include "sv32_translating_memory_unit_macros.svh"

module sv32_translating_memory_unit #(
  parameter int MEM_PAGES = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [21:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // {pad, wdata[67:36], addr[35:4], physical[3], func[2:0]}
  input  logic [71:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // {pad, phys_addr[101:68], fault_value[67:34], status[33:32], rdata[31:0]}
  output logic [103:0] m_axis_tdata
);

  localparam int unsigned WORDS = MEM_PAGES * 1024;
  localparam int unsigned AW = $clog2(WORDS);
  localparam logic [35:0] MAX_PA = 36'(MEM_PAGES) << 12;

  typedef enum logic [2:0] {
    S_IDLE, S_L1, S_L1W, S_L0, S_L0W, S_CHK, S_DAT, S_DONE
  } state_e;

  state_e       state_q;
  logic         trans_en_q;
  logic [21:0]  root_q;
  logic [2:0]   func_q;
  logic [31:0]  va_q;
  logic [31:0]  wdata_q;
  logic [21:0]  base_q;
  logic [33:0]  pa_q;
  logic [31:0]  res_rdata_q;
  logic [1:0]   res_status_q;
  logic [33:0]  res_fv_q;
  logic [33:0]  res_pa_q;
  logic         out_valid_q;
  logic [103:0] out_data_q;

  logic [31:0]  mem [WORDS];
  logic [31:0]  mem_rdata_q;
  logic [AW-1:0] mem_addr;
  logic         mem_re;
  logic         mem_we;
  logic [31:0]  mem_wdata;

  logic         s_accept;
  logic [9:0]   vpn;
  logic [33:0]  pte_loc;
  logic         pte_oob;
  logic [1:0]   sz;
  logic [35:0]  last_byte;
  logic         pa_oob;
  logic         pa_mis;
  logic [4:0]   lane_sh;
  logic [31:0]  lane_mask;
  logic [31:0]  pte;
  logic         pte_bad;
  logic         pte_leaf;
  logic         leaf_fault_l1;
  logic         leaf_fault_l0;
  logic         kind_store;
  logic         kind_fetch;
  logic         perm_ok;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // PTE address for the current walk level
  assign vpn      = (state_q == S_L1) ? va_q[31:22] : va_q[21:12];
  assign pte_loc  = {base_q, 12'b0} + {22'b0, vpn, 2'b00};
  assign pte_oob  = ({2'b0, pte_loc} + 36'd3) > MAX_PA;

  // bounds and alignment of the data access
  assign sz        = sv32tm_pkg::size_log2(func_q);
  assign last_byte = {2'b0, pa_q} + 36'((1 << sz) - 1);
  assign pa_oob    = (sz == 2'd0) ? ({2'b0, pa_q} >= MAX_PA) : (last_byte > MAX_PA);
  assign pa_mis    = (sz == 2'd2) ? (pa_q[1:0] != 2'b00)
                   : (sz == 2'd1) ? pa_q[0] : 1'b0;
  assign lane_sh   = (sz == 2'd0) ? {pa_q[1:0], 3'b000}
                   : (sz == 2'd1) ? {pa_q[1], 4'b0000} : 5'd0;
  assign lane_mask = (sz == 2'd0) ? 32'h0000_00ff
                   : (sz == 2'd1) ? 32'h0000_ffff : 32'hffff_ffff;

  // PTE checks on the word just read
  assign kind_store = sv32tm_pkg::is_store(func_q);
  assign kind_fetch = (func_q == sv32tm_pkg::FUNC_FETCH);
  assign pte        = mem_rdata_q;
  assign pte_bad    = !pte[sv32tm_pkg::PTE_V] ||
                      (!pte[sv32tm_pkg::PTE_R] && pte[sv32tm_pkg::PTE_W]);
  assign pte_leaf   = pte[sv32tm_pkg::PTE_R] || pte[sv32tm_pkg::PTE_X];
  assign perm_ok    = kind_store ? pte[sv32tm_pkg::PTE_W]
                    : kind_fetch ? pte[sv32tm_pkg::PTE_X] : pte[sv32tm_pkg::PTE_R];
  assign leaf_fault_l0 = !perm_ok || !pte[sv32tm_pkg::PTE_A] ||
                         (kind_store && !pte[sv32tm_pkg::PTE_D]);
  // a superpage must be aligned: PPN[0] clear
  assign leaf_fault_l1 = leaf_fault_l0 || (pte[19:10] != 10'd0);

  always_comb begin
    mem_addr  = pa_q[AW+1:2];
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_wdata = (mem_rdata_q & ~(lane_mask << lane_sh)) |
                ((wdata_q & lane_mask) << lane_sh);
    case (state_q)
      S_L1, S_L0: begin
        mem_addr = pte_loc[AW+1:2];
        mem_re   = !pte_oob;
      end
      S_CHK: mem_re = !pa_oob && !pa_mis;
      S_DAT: mem_we = kind_store;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      trans_en_q   <= 1'b0;
      root_q       <= '0;
      func_q       <= '0;
      va_q         <= '0;
      wdata_q      <= '0;
      base_q       <= '0;
      pa_q         <= '0;
      res_rdata_q  <= '0;
      res_status_q <= sv32tm_pkg::ST_OK;
      res_fv_q     <= '0;
      res_pa_q     <= '0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          sv32tm_pkg::CFG_TRANSLATE: trans_en_q <= cfg_wdata_i[0];
          sv32tm_pkg::CFG_ROOT:      root_q     <= cfg_wdata_i;
          default: ;
        endcase
      end
      // S_DONE refills the output register itself
      if (out_valid_q && m_axis_tready && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (s_accept) begin
            func_q       <= s_axis_tdata[2:0];
            va_q         <= s_axis_tdata[35:4];
            wdata_q      <= s_axis_tdata[67:36];
            base_q       <= root_q;
            pa_q         <= {2'b0, s_axis_tdata[35:4]};
            res_rdata_q  <= '0;
            res_status_q <= sv32tm_pkg::ST_OK;
            res_fv_q     <= '0;
            res_pa_q     <= '0;
            if (s_axis_tdata[2:0] == sv32tm_pkg::FUNC_NOP) begin
              state_q <= S_DONE;
            end else if (trans_en_q && !s_axis_tdata[3]) begin
              state_q <= S_L1;
            end else begin
              state_q <= S_CHK;
            end
          end
        end
        S_L1, S_L0: begin
          if (pte_oob) begin
            res_status_q <= sv32tm_pkg::ST_OOM;
            res_fv_q     <= pte_loc;
            state_q      <= S_DONE;
          end else begin
            state_q <= (state_q == S_L1) ? S_L1W : S_L0W;
          end
        end
        S_L1W, S_L0W: begin
          if (pte_bad || (!pte_leaf && state_q == S_L0W) ||
              (pte_leaf && state_q == S_L1W && leaf_fault_l1) ||
              (pte_leaf && state_q == S_L0W && leaf_fault_l0)) begin
            res_status_q <= sv32tm_pkg::ST_PAGE;
            res_fv_q     <= {2'b0, pte};
            state_q      <= S_DONE;
          end else if (!pte_leaf) begin
            base_q  <= pte[31:10];
            state_q <= S_L0;
          end else begin
            pa_q    <= (state_q == S_L1W) ? {pte[31:20], va_q[21:0]}
                                          : {pte[31:10], va_q[11:0]};
            state_q <= S_CHK;
          end
        end
        S_CHK: begin
          res_pa_q <= pa_q;
          if (pa_oob) begin
            res_status_q <= sv32tm_pkg::ST_OOM;
            res_fv_q     <= pa_q;
            state_q      <= S_DONE;
          end else if (pa_mis) begin
            res_status_q <= sv32tm_pkg::ST_MISALIGN;
            res_fv_q     <= pa_q;
            state_q      <= S_DONE;
          end else begin
            state_q <= S_DAT;
          end
        end
        S_DAT: begin
          if (!kind_store) begin
            res_rdata_q <= (mem_rdata_q >> lane_sh) & lane_mask;
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          // hand off once the output register is free
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {2'b0, res_pa_q, res_fv_q, res_status_q, res_rdata_q};
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `SV32_ASSERT(a_write_only_in_data, mem_we |-> (state_q == S_DAT))
  `SV32_ASSERT(a_accept_leaves_idle, s_accept |=> (state_q != S_IDLE))
  `SV32_ASSERT(a_ok_no_fault, (out_valid_q && out_data_q[33:32] == sv32tm_pkg::ST_OK)
    |-> (out_data_q[67:34] == 34'd0))
  `SV32_ASSERT(a_page_fault_no_pa,
    (out_valid_q && out_data_q[33:32] == sv32tm_pkg::ST_PAGE)
    |-> (out_data_q[101:68] == 34'd0 && out_data_q[31:0] == 32'd0))

endmodule
